// ----- src/jhfs_pkg.sv -----
// ----------------------------------------------------------------------------
// jhfs_pkg
// Types and constants shared by the marker fixup and byte stuffing block.
// ----------------------------------------------------------------------------
package jhfs_pkg;

  typedef enum logic [10:0] {
    PH_MARK_FF   = 11'b000_0000_0001,
    PH_MARK_CODE = 11'b000_0000_0010,
    PH_SEG_HI    = 11'b000_0000_0100,
    PH_SEG_LO    = 11'b000_0000_1000,
    PH_SEG_BODY  = 11'b000_0001_0000,
    PH_SOS_HI    = 11'b000_0010_0000,
    PH_SOS_LO    = 11'b000_0100_0000,
    PH_SOS_BODY  = 11'b000_1000_0000,
    PH_SCAN      = 11'b001_0000_0000,
    PH_DONE      = 11'b010_0000_0000,
    PH_HALT      = 11'b100_0000_0000
  } phase_e;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_APP    = 8'hA0;
  localparam logic [7:0] MK_SOF    = 8'hC0;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] SOS_LEN   = 8'h0C;
  localparam logic [7:0] SOS_SE    = 8'h3F;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_BAD_CODE  = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  localparam int unsigned TOTAL_BITS = 24;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            sonly;
    logic            fin;
    logic [1:0]      status;
  } job_t;

endpackage

// ----- src/jhfs_front.sv -----
// ----------------------------------------------------------------------------
// jhfs_front
// Parses the input stream and turns each item into at most one job of up to four bytes.
// ----------------------------------------------------------------------------
module jhfs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output jhfs_pkg::job_t q_job_o
);

  jhfs_pkg::phase_e phase_q, phase_d;
  logic [15:0]      rem_q, rem_d;
  logic [7:0]       lenh_q, lenh_d;
  logic             pend_q, pend_d;

  logic             accept;
  logic             active;
  logic [2:0]       n;
  logic             fin;
  logic [1:0]       st;
  logic [3:0][7:0]  bytes;
  logic [15:0]      len16;
  logic [15:0]      body;

  assign accept = push_i && !q_full_i;
  assign active = (phase_q != jhfs_pkg::PH_DONE) && (phase_q != jhfs_pkg::PH_HALT);
  assign len16  = {lenh_q, in_byte_i};
  assign body   = (len16 < 16'd2) ? 16'd0 : len16 - 16'd2;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    lenh_d  = lenh_q;
    pend_d  = pend_q;
    n       = 3'd0;
    fin     = 1'b0;
    st      = jhfs_pkg::ST_OK;
    bytes   = '0;
    unique case (phase_q) inside
      jhfs_pkg::PH_MARK_FF: begin
        if (in_byte_i != jhfs_pkg::MK_PREFIX) begin
          fin     = 1'b1;
          st      = jhfs_pkg::ST_BAD_PREFIX;
          phase_d = jhfs_pkg::PH_HALT;
        end else begin
          phase_d = jhfs_pkg::PH_MARK_CODE;
        end
      end
      jhfs_pkg::PH_MARK_CODE: begin
        bytes[0] = jhfs_pkg::MK_PREFIX;
        bytes[1] = in_byte_i;
        if (in_byte_i == jhfs_pkg::MK_SOI) begin
          n       = 3'd2;
          phase_d = jhfs_pkg::PH_MARK_FF;
        end else if (in_byte_i == jhfs_pkg::MK_APP) begin
          phase_d = jhfs_pkg::PH_MARK_FF;
        end else if (in_byte_i == jhfs_pkg::MK_SOF || in_byte_i == jhfs_pkg::MK_DHT ||
                     in_byte_i == jhfs_pkg::MK_DQT) begin
          n       = 3'd2;
          phase_d = jhfs_pkg::PH_SEG_HI;
        end else if (in_byte_i == jhfs_pkg::MK_SOS) begin
          n        = 3'd4;
          bytes[2] = jhfs_pkg::BYTE_ZERO;
          bytes[3] = jhfs_pkg::SOS_LEN;
          phase_d  = jhfs_pkg::PH_SOS_HI;
        end else if (in_byte_i == jhfs_pkg::MK_EOI) begin
          n       = 3'd2;
          fin     = 1'b1;
          phase_d = jhfs_pkg::PH_DONE;
        end else begin
          fin     = 1'b1;
          st      = jhfs_pkg::ST_BAD_CODE;
          phase_d = jhfs_pkg::PH_HALT;
        end
      end
      jhfs_pkg::PH_SEG_HI: begin
        n        = 3'd1;
        bytes[0] = in_byte_i;
        lenh_d   = in_byte_i;
        phase_d  = jhfs_pkg::PH_SEG_LO;
      end
      jhfs_pkg::PH_SEG_LO: begin
        n        = 3'd1;
        bytes[0] = in_byte_i;
        rem_d    = body;
        phase_d  = (body != 16'd0) ? jhfs_pkg::PH_SEG_BODY : jhfs_pkg::PH_MARK_FF;
      end
      jhfs_pkg::PH_SEG_BODY: begin
        n        = 3'd1;
        bytes[0] = in_byte_i;
        rem_d    = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          phase_d = jhfs_pkg::PH_MARK_FF;
        end
      end
      jhfs_pkg::PH_SOS_HI: begin
        lenh_d  = in_byte_i;
        phase_d = jhfs_pkg::PH_SOS_LO;
      end
      jhfs_pkg::PH_SOS_LO: begin
        rem_d = body;
        if (body == 16'd0) begin
          n        = 3'd3;
          bytes[0] = jhfs_pkg::BYTE_ZERO;
          bytes[1] = jhfs_pkg::SOS_SE;
          bytes[2] = jhfs_pkg::BYTE_ZERO;
          phase_d  = jhfs_pkg::PH_SCAN;
        end else begin
          phase_d = jhfs_pkg::PH_SOS_BODY;
        end
      end
      jhfs_pkg::PH_SOS_BODY: begin
        n        = 3'd1;
        bytes[0] = in_byte_i;
        rem_d    = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          n        = 3'd4;
          bytes[1] = jhfs_pkg::BYTE_ZERO;
          bytes[2] = jhfs_pkg::SOS_SE;
          bytes[3] = jhfs_pkg::BYTE_ZERO;
          phase_d  = jhfs_pkg::PH_SCAN;
        end
      end
      jhfs_pkg::PH_SCAN: begin
        if (pend_q && in_byte_i == jhfs_pkg::MK_EOI && in_last_i) begin
          n        = 3'd2;
          bytes[0] = jhfs_pkg::MK_PREFIX;
          bytes[1] = jhfs_pkg::MK_EOI;
          fin      = 1'b1;
          pend_d   = 1'b0;
          phase_d  = jhfs_pkg::PH_DONE;
        end else if (pend_q) begin
          bytes[0] = jhfs_pkg::MK_PREFIX;
          bytes[1] = jhfs_pkg::BYTE_ZERO;
          pend_d   = 1'b0;
          if (in_byte_i == jhfs_pkg::MK_PREFIX) begin
            if (in_last_i) begin
              n        = 3'd4;
              bytes[2] = jhfs_pkg::MK_PREFIX;
              bytes[3] = jhfs_pkg::BYTE_ZERO;
            end else begin
              n      = 3'd2;
              pend_d = 1'b1;
            end
          end else begin
            n        = 3'd3;
            bytes[2] = in_byte_i;
          end
        end else if (in_byte_i == jhfs_pkg::MK_PREFIX) begin
          if (in_last_i) begin
            n        = 3'd2;
            bytes[0] = jhfs_pkg::MK_PREFIX;
            bytes[1] = jhfs_pkg::BYTE_ZERO;
          end else begin
            pend_d = 1'b1;
          end
        end else begin
          n        = 3'd1;
          bytes[0] = in_byte_i;
        end
      end
      jhfs_pkg::PH_DONE, jhfs_pkg::PH_HALT: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = jhfs_pkg::PH_HALT;
      end
    endcase
    if (in_last_i && active && phase_d != jhfs_pkg::PH_DONE &&
        phase_d != jhfs_pkg::PH_HALT) begin
      fin     = 1'b1;
      st      = jhfs_pkg::ST_TRUNC;
      pend_d  = 1'b0;
      phase_d = jhfs_pkg::PH_HALT;
    end
  end

  always_comb begin
    q_job_o.bytes    = (n == 3'd0) ? '0 : bytes;
    q_job_o.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    q_job_o.sonly    = (n == 3'd0);
    q_job_o.fin      = fin;
    q_job_o.status   = st;
  end

  assign q_push_o = accept && active && ((n != 3'd0) || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jhfs_pkg::PH_MARK_FF;
      rem_q   <= '0;
      lenh_q  <= '0;
      pend_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      lenh_q  <= lenh_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ----- src/jhfs_queue.sv -----
// ----------------------------------------------------------------------------
// jhfs_queue
// Two-entry job queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module jhfs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  jhfs_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output jhfs_pkg::job_t rd_job_o,
  output logic           full_o,
  output logic           empty_o
);

  jhfs_pkg::job_t mem_q [2];
  logic           wp_q;
  logic           rp_q;
  logic [1:0]     cnt_q;
  logic           do_wr;
  logic           do_rd;

  assign full_o   = (cnt_q == 2'd2);
  assign empty_o  = (cnt_q == 2'd0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_q <= ~wp_q;
      end
      if (do_rd) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// ----- src/jhfs_back.sv -----
// ----------------------------------------------------------------------------
// jhfs_back
// Walks the head job one byte per pop and keeps the saturating byte count.
// ----------------------------------------------------------------------------
module jhfs_back #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jhfs_pkg::job_t job_i,
  input  logic           q_empty_i,
  input  logic           pop_i,
  output logic           q_rd_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic [1:0]     status_o,
  output logic [23:0]    out_total_o
);

  logic [1:0]            idx_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [COUNT_BITS-1:0] cnt_disp;
  logic                  take;
  logic                  at_end;

  assign take   = pop_i && !q_empty_i;
  assign at_end = (idx_q == job_i.last_idx);
  assign q_rd_o = take && at_end;

  always_comb begin
    cnt_disp = cnt_q;
    if (!job_i.sonly && cnt_q != {COUNT_BITS{1'b1}}) begin
      cnt_disp = cnt_q + COUNT_BITS'(1);
    end
  end

  assign out_byte_o = job_i.bytes[idx_q];
  assign out_last_o = job_i.fin && at_end;
  assign status_o   = out_last_o ? job_i.status : jhfs_pkg::ST_OK;

  if (COUNT_BITS > jhfs_pkg::TOTAL_BITS) begin : g_sat
    assign out_total_o = (|cnt_disp[COUNT_BITS-1:jhfs_pkg::TOTAL_BITS]) ? '1 :
                         cnt_disp[jhfs_pkg::TOTAL_BITS-1:0];
  end else begin : g_ext
    assign out_total_o = jhfs_pkg::TOTAL_BITS'(cnt_disp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      cnt_q <= '0;
    end else if (take) begin
      idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      cnt_q <= cnt_disp;
    end
  end

endmodule

// ----- src/jpeg_header_fixup_stuffer.sv -----
// ----------------------------------------------------------------------------
// jpeg_header_fixup_stuffer
// Rewrites variant JPEG marker layout to standard JPEG with FF00 stuffing.
// ----------------------------------------------------------------------------
// An input item is taken in the cycle it is pushed whenever the two-entry job
// queue has room, so items can arrive back to back; each item yields zero to
// four result bytes, and the emitter hands out one result per cycle while pop
// is held, the first one in the cycle after the item is taken at the earliest.
// The sustained rate is therefore set by the output port and by how many
// results each item yields. After a final result (end marker, error or
// truncation) the block swallows further items without results until reset.
module jpeg_header_fixup_stuffer #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [1:0]  status_o,
  output logic [23:0] out_total_o
);

  jhfs_pkg::job_t wr_job;
  jhfs_pkg::job_t rd_job;
  logic           q_push;
  logic           q_rd;

  jhfs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .q_full_i  (full),
    .q_push_o  (q_push),
    .q_job_o   (wr_job)
  );

  jhfs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_push),
    .wr_job_i (wr_job),
    .rd_i     (q_rd),
    .rd_job_o (rd_job),
    .full_o   (full),
    .empty_o  (empty)
  );

  jhfs_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (rd_job),
    .q_empty_i   (empty),
    .pop_i       (pop),
    .q_rd_o      (q_rd),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o),
    .out_total_o (out_total_o)
  );

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty) else $error("queue full while empty");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != jhfs_pkg::ST_OK) |-> out_last_o)
    else $error("error status on a non-final item");

  a_nothing_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && out_last_o) |=> empty)
    else $error("item after final item");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) ##1 !empty |-> out_total_o >= $past(out_total_o))
    else $error("byte total went down");

endmodule

// ----- dv/jpeg_header_fixup_stuffer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpeg_header_fixup_stuffer_test
// Pushes one variant JPEG stream through the block and checks every output
// byte, flag, status and running count against a predictor kept in a small
// scoreboard. The stream opens with hand-picked marker segments and goes on
// with random segments, an optional scan with stuffing, and one randomly
// chosen ending (end marker, error, or truncation), then a few items that
// must be swallowed. Both sides idle at random; the sink also holds off for
// a long stretch and the source drains once.
// ----------------------------------------------------------------------------
module jpeg_header_fixup_stuffer_test;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [23:0] total;
  } std_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } var_byte_t;

  typedef enum {
    END_EOI_SCAN, END_FF_LAST, END_DATA_LAST, END_EOI_MARK,
    END_BAD_PREFIX, END_BAD_CODE, END_TRUNC_HDR
  } stream_end_e;

  class jpeg_fixup_scoreboard;
    jhfs_pkg::phase_e phase;
    logic [15:0]      seg_left;
    logic [7:0]       len_hi;
    bit               ff_wait;
    longint unsigned  emitted;
    std_byte_t        std_bytes_q[$];
    std_byte_t        step_q[$];
    int               errors;
    int               checked;

    function new();
      phase    = jhfs_pkg::PH_MARK_FF;
      seg_left = '0;
      len_hi   = '0;
      ff_wait  = 0;
      emitted  = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function logic [23:0] total_now();
      return (emitted > 64'hFF_FFFF) ? 24'hFF_FFFF : emitted[23:0];
    endfunction

    function void put_byte(logic [7:0] b);
      std_byte_t r;
      if (emitted < ((64'd1 << COUNT_BITS) - 1)) emitted++;
      r.data   = b;
      r.last   = 0;
      r.status = jhfs_pkg::ST_OK;
      r.total  = total_now();
      step_q   = {step_q, r};
    endfunction

    function void close_stream(logic [1:0] st);
      std_byte_t r;
      if (step_q.size() == 0) begin
        r.data  = jhfs_pkg::BYTE_ZERO;
        r.total = total_now();
      end else begin
        r = step_q.pop_back();
      end
      r.last   = 1;
      r.status = st;
      step_q   = {step_q, r};
    endfunction

    function logic [15:0] body_count(logic [7:0] lo);
      logic [15:0] n;
      n = {len_hi, lo};
      return (n < 16'd2) ? 16'd0 : n - 16'd2;
    endfunction

    function void end_sos_header();
      put_byte(jhfs_pkg::BYTE_ZERO);
      put_byte(jhfs_pkg::SOS_SE);
      put_byte(jhfs_pkg::BYTE_ZERO);
      phase = jhfs_pkg::PH_SCAN;
    endfunction

    function void note_input(logic [7:0] b, logic l);
      bit eoi_seen;
      eoi_seen = 0;
      step_q.delete();
      if (phase != jhfs_pkg::PH_DONE && phase != jhfs_pkg::PH_HALT) begin
        case (phase)
          jhfs_pkg::PH_MARK_FF: begin
            if (b != jhfs_pkg::MK_PREFIX) begin
              close_stream(jhfs_pkg::ST_BAD_PREFIX);
              phase = jhfs_pkg::PH_HALT;
            end else begin
              phase = jhfs_pkg::PH_MARK_CODE;
            end
          end
          jhfs_pkg::PH_MARK_CODE: begin
            if (b == jhfs_pkg::MK_SOI) begin
              put_byte(jhfs_pkg::MK_PREFIX);
              put_byte(jhfs_pkg::MK_SOI);
              phase = jhfs_pkg::PH_MARK_FF;
            end else if (b == jhfs_pkg::MK_APP) begin
              phase = jhfs_pkg::PH_MARK_FF;
            end else if (b == jhfs_pkg::MK_SOF || b == jhfs_pkg::MK_DHT ||
                         b == jhfs_pkg::MK_DQT) begin
              put_byte(jhfs_pkg::MK_PREFIX);
              put_byte(b);
              phase = jhfs_pkg::PH_SEG_HI;
            end else if (b == jhfs_pkg::MK_SOS) begin
              put_byte(jhfs_pkg::MK_PREFIX);
              put_byte(jhfs_pkg::MK_SOS);
              put_byte(jhfs_pkg::BYTE_ZERO);
              put_byte(jhfs_pkg::SOS_LEN);
              phase = jhfs_pkg::PH_SOS_HI;
            end else if (b == jhfs_pkg::MK_EOI) begin
              put_byte(jhfs_pkg::MK_PREFIX);
              put_byte(jhfs_pkg::MK_EOI);
              close_stream(jhfs_pkg::ST_OK);
              phase = jhfs_pkg::PH_DONE;
            end else begin
              close_stream(jhfs_pkg::ST_BAD_CODE);
              phase = jhfs_pkg::PH_HALT;
            end
          end
          jhfs_pkg::PH_SEG_HI: begin
            put_byte(b);
            len_hi = b;
            phase  = jhfs_pkg::PH_SEG_LO;
          end
          jhfs_pkg::PH_SEG_LO: begin
            put_byte(b);
            seg_left = body_count(b);
            phase    = (seg_left != 0) ? jhfs_pkg::PH_SEG_BODY : jhfs_pkg::PH_MARK_FF;
          end
          jhfs_pkg::PH_SEG_BODY: begin
            put_byte(b);
            seg_left = seg_left - 16'd1;
            if (seg_left == 0) phase = jhfs_pkg::PH_MARK_FF;
          end
          jhfs_pkg::PH_SOS_HI: begin
            len_hi = b;
            phase  = jhfs_pkg::PH_SOS_LO;
          end
          jhfs_pkg::PH_SOS_LO: begin
            seg_left = body_count(b);
            if (seg_left == 0) end_sos_header();
            else phase = jhfs_pkg::PH_SOS_BODY;
          end
          jhfs_pkg::PH_SOS_BODY: begin
            put_byte(b);
            seg_left = seg_left - 16'd1;
            if (seg_left == 0) end_sos_header();
          end
          default: begin
            if (ff_wait) begin
              ff_wait = 0;
              if (b == jhfs_pkg::MK_EOI && l) begin
                put_byte(jhfs_pkg::MK_PREFIX);
                put_byte(jhfs_pkg::MK_EOI);
                close_stream(jhfs_pkg::ST_OK);
                phase    = jhfs_pkg::PH_DONE;
                eoi_seen = 1;
              end else begin
                put_byte(jhfs_pkg::MK_PREFIX);
                put_byte(jhfs_pkg::BYTE_ZERO);
              end
            end
            if (!eoi_seen) begin
              if (b == jhfs_pkg::MK_PREFIX) begin
                if (l) begin
                  put_byte(jhfs_pkg::MK_PREFIX);
                  put_byte(jhfs_pkg::BYTE_ZERO);
                end else begin
                  ff_wait = 1;
                end
              end else begin
                put_byte(b);
              end
            end
          end
        endcase
        if (l && phase != jhfs_pkg::PH_DONE && phase != jhfs_pkg::PH_HALT) begin
          close_stream(jhfs_pkg::ST_TRUNC);
          ff_wait = 0;
          phase   = jhfs_pkg::PH_HALT;
        end
      end
      std_bytes_q = {std_bytes_q, step_q};
    endfunction

    function void check_output(logic [7:0] b, logic l, logic [1:0] st, logic [23:0] tot);
      std_byte_t e;
      if (std_bytes_q.size() == 0) begin
        $error("unexpected output: out_byte %h out_last %b status %0d out_total %0d",
               b, l, st, tot);
        errors++;
      end else begin
        e = std_bytes_q.pop_front();
        checked++;
        if (b !== e.data) begin
          $error("out_byte: expected %h, got %h", e.data, b);
          errors++;
        end
        if (l !== e.last) begin
          $error("out_last: expected %b, got %b", e.last, l);
          errors++;
        end
        if (st !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, st);
          errors++;
        end
        if (tot !== e.total) begin
          $error("out_total: expected %0d, got %0d", e.total, tot);
          errors++;
        end
      end
    endfunction

    function int pending();
      return std_bytes_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte_i;
  logic        in_last_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic [1:0]  status_o;
  logic [23:0] out_total_o;

  jpeg_fixup_scoreboard sb;
  var_byte_t            stream_q[$];
  stream_end_e          stream_end;
  int                   idle_pct = 12;
  int                   sink_hold = 0;
  int                   cycles = 0;
  int                   items_pushed = 0;
  int                   ignored_items = 0;

  jpeg_header_fixup_stuffer #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .status_o   (status_o),
    .out_total_o(out_total_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sink side
  initial begin
    pop = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        pop <= 0;
        sink_hold--;
      end else begin
        pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_output(out_byte_o, out_last_o, status_o, out_total_o);
  end

  function automatic void add_item(logic [7:0] b, logic l);
    var_byte_t r;
    r.data   = b;
    r.last   = l;
    stream_q = {stream_q, r};
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return jhfs_pkg::BYTE_ZERO;
      1:       return jhfs_pkg::MK_PREFIX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] unknown_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == jhfs_pkg::MK_SOI || c == jhfs_pkg::MK_APP ||
               c == jhfs_pkg::MK_SOF || c == jhfs_pkg::MK_DHT ||
               c == jhfs_pkg::MK_DQT || c == jhfs_pkg::MK_SOS ||
               c == jhfs_pkg::MK_EOI);
    return c;
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 19))
      0:       return 16'($urandom_range(0, 1));
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic void add_segment(logic [7:0] code, logic [15:0] len);
    add_item(jhfs_pkg::MK_PREFIX, 1'b0);
    add_item(code, 1'b0);
    add_item(len[15:8], 1'b0);
    add_item(len[7:0], 1'b0);
    for (int k = 2; k < len; k++) add_item(rand_data(), 1'b0);
  endfunction

  function automatic void add_random_header();
    case ($urandom_range(0, 9))
      0: begin
        add_item(jhfs_pkg::MK_PREFIX, 1'b0);
        add_item(jhfs_pkg::MK_SOI, 1'b0);
      end
      1: begin
        add_item(jhfs_pkg::MK_PREFIX, 1'b0);
        add_item(jhfs_pkg::MK_APP, 1'b0);
      end
      2, 3, 4: add_segment(jhfs_pkg::MK_SOF, pick_length());
      5, 6:    add_segment(jhfs_pkg::MK_DHT, pick_length());
      default: add_segment(jhfs_pkg::MK_DQT, pick_length());
    endcase
  endfunction

  function automatic void add_scan_bytes(int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: add_item(jhfs_pkg::MK_PREFIX, 1'b0);
        2: begin
          add_item(jhfs_pkg::MK_PREFIX, 1'b0);
          add_item(jhfs_pkg::MK_EOI, 1'b0);
        end
        default: add_item(rand_data(), 1'b0);
      endcase
    end
  endfunction

  function automatic void build_stream();
    int        base;
    int        keep;
    int        hdr_target;
    var_byte_t r;
    case ($urandom_range(0, 9))
      0, 1, 2: stream_end = END_EOI_SCAN;
      3:       stream_end = END_FF_LAST;
      4:       stream_end = END_DATA_LAST;
      5:       stream_end = END_EOI_MARK;
      6:       stream_end = END_BAD_PREFIX;
      7:       stream_end = END_BAD_CODE;
      default: stream_end = END_TRUNC_HDR;
    endcase
    hdr_target = (stream_end == END_EOI_SCAN || stream_end == END_FF_LAST ||
                  stream_end == END_DATA_LAST) ? 290 : 410;

    // directed header: pass-through, drop, short lengths, edge body bytes
    add_item(jhfs_pkg::MK_PREFIX, 1'b0); add_item(jhfs_pkg::MK_SOI, 1'b0);
    add_item(jhfs_pkg::MK_PREFIX, 1'b0); add_item(jhfs_pkg::MK_APP, 1'b0);
    add_segment(jhfs_pkg::MK_DQT, 16'd0);
    add_segment(jhfs_pkg::MK_DHT, 16'd1);
    add_segment(jhfs_pkg::MK_SOF, 16'd2);
    add_item(jhfs_pkg::MK_PREFIX, 1'b0); add_item(jhfs_pkg::MK_DQT, 1'b0);
    add_item(jhfs_pkg::BYTE_ZERO, 1'b0); add_item(8'h04, 1'b0);
    add_item(jhfs_pkg::BYTE_ZERO, 1'b0); add_item(jhfs_pkg::MK_PREFIX, 1'b0);
    // long segment with a nonzero high length byte
    add_segment(jhfs_pkg::MK_DQT, 16'h0101);
    while (stream_q.size() < hdr_target) add_random_header();

    case (stream_end)
      END_EOI_MARK: begin
        add_item(jhfs_pkg::MK_PREFIX, 1'b0);
        add_item(jhfs_pkg::MK_EOI, 1'($urandom_range(0, 1)));
      end
      END_BAD_PREFIX: add_item(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));
      END_BAD_CODE: begin
        add_item(jhfs_pkg::MK_PREFIX, 1'b0);
        add_item(unknown_code(), 1'($urandom_range(0, 1)));
      end
      END_TRUNC_HDR: begin
        base = stream_q.size();
        if ($urandom_range(0, 1)) add_segment(jhfs_pkg::MK_SOS, pick_length());
        else add_random_header();
        keep = $urandom_range(1, stream_q.size() - base);
        while (stream_q.size() > base + keep) void'(stream_q.pop_back());
        r        = stream_q.pop_back();
        r.last   = 1;
        stream_q = {stream_q, r};
      end
      default: begin
        if ($urandom_range(0, 4) == 0) begin
          add_segment(jhfs_pkg::MK_SOS, 16'($urandom_range(0, 1)));
        end else begin
          add_segment(jhfs_pkg::MK_SOS, 16'($urandom_range(2, 10)));
        end
        // scan edge cases: end marker without last, FF run, stuffed zero
        add_item(jhfs_pkg::MK_PREFIX, 1'b0); add_item(jhfs_pkg::MK_EOI, 1'b0);
        add_item(jhfs_pkg::MK_PREFIX, 1'b0); add_item(jhfs_pkg::MK_PREFIX, 1'b0);
        add_item(jhfs_pkg::BYTE_ZERO, 1'b0);
        add_item(jhfs_pkg::MK_PREFIX, 1'b0); add_item(jhfs_pkg::BYTE_ZERO, 1'b0);
        add_item(8'h7F, 1'b0);
        add_scan_bytes(100);
        case (stream_end)
          END_EOI_SCAN: begin
            add_item(jhfs_pkg::MK_PREFIX, 1'b0);
            add_item(jhfs_pkg::MK_EOI, 1'b1);
          end
          END_FF_LAST: add_item(jhfs_pkg::MK_PREFIX, 1'b1);
          default:     add_item(8'($urandom_range(0, 254)), 1'b1);
        endcase
      end
    endcase

    // swallowed after the end
    repeat (6) begin
      add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      ignored_items++;
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      push <= 0;
      @(negedge clk_i);
    end
    push      <= 1;
    in_byte_i <= b;
    in_last_i <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(b, l);
    items_pushed++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb        = new();
    rst_ni    = 0;
    push      = 0;
    in_byte_i = '0;
    in_last_i = 0;
    build_stream();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    foreach (stream_q[i]) begin
      if (i == 40) sink_hold = 200;
      if (i == 100) drain_results();
      idle_pct = (i >= 110 && i < 190) ? 0 : 12;
      send_item(stream_q[i].data, stream_q[i].last);
    end
    idle_pct = 12;
    @(negedge clk_i);
    push <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("tb: %0d items pushed (%0d after the stream end), %0d output bytes checked",
             items_pushed, ignored_items, sb.checked);
    $display("tb: stream ending %s, with sink hold-off and source drain", stream_end.name());
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
